@@ rtl/swmm_pkg.sv @@
package swmm_pkg;

	localparam int WINDOW_MAX   = 64;
	localparam int SAMPLE_WIDTH = 32;
	localparam int WSIZE_W      = $clog2(WINDOW_MAX + 1);
	localparam int IDX_W        = $clog2(WINDOW_MAX);

	localparam logic [WSIZE_W-1:0] WSIZE_RESET = WSIZE_W'(3);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [WSIZE_W-1:0]             wsize_t;
	typedef logic [IDX_W-1:0]               idx_t;

	typedef struct packed {
		logic shift;
		logic restart;
	} cell_ctrl_t;

endpackage

@@ rtl/swmm_if.sv @@
interface swmm_sample_if;
	logic              valid;
	logic              ready;
	swmm_pkg::sample_t sample;
	logic              stream_start;

	modport source (output valid, output sample, output stream_start, input ready);
	modport sink   (input valid, input sample, input stream_start, output ready);
endinterface

interface swmm_result_if;
	logic              valid;
	logic              ready;
	swmm_pkg::sample_t window_min;
	swmm_pkg::sample_t window_max;

	modport source (output valid, output window_min, output window_max, input ready);
	modport sink   (input valid, input window_min, input window_max, output ready);
endinterface

@@ rtl/swmm_cell.sv @@
module swmm_cell (
	input  logic                 clk,
	input  swmm_pkg::cell_ctrl_t ctrl,
	input  swmm_pkg::sample_t    sample,
	input  swmm_pkg::sample_t    prev_min,
	input  swmm_pkg::sample_t    prev_max,
	output swmm_pkg::sample_t    min_q,
	output swmm_pkg::sample_t    max_q
);

	// cell k holds min/max over the last k+1 samples of the current stream
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			if (ctrl.restart) begin
				min_q <= sample;
				max_q <= sample;
			end else begin
				min_q <= (prev_min < sample) ? prev_min : sample;
				max_q <= (prev_max > sample) ? prev_max : sample;
			end
		end
	end

endmodule

@@ rtl/sliding_window_min_max.sv @@
// Latency: a result beat is valid the cycle after its sample beat is accepted.
// Throughput: one sample per cycle when no unread result stalls it; all cells
// update in parallel and the result is what cell window_size - 1 takes on the beat.
// Reset: arst_n clears the sample count and output valid, and loads window_size = 3.
// Cell contents are not reset; no result is produced until a full window is seen.
module sliding_window_min_max (
	input  logic                          clk,
	input  logic                          arst_n,
	swmm_sample_if.sink                   samples,
	swmm_result_if.source                 results,
	input  logic                          cfg_we,
	input  logic [swmm_pkg::WSIZE_W-1:0]  cfg_wdata
);

	swmm_pkg::wsize_t     wsize_q;
	swmm_pkg::wsize_t     seen_q;
	swmm_pkg::wsize_t     weff;
	swmm_pkg::wsize_t     seen_base;
	swmm_pkg::wsize_t     seen_next;
	swmm_pkg::idx_t       sel;
	swmm_pkg::cell_ctrl_t ctrl;
	swmm_pkg::sample_t    cmin_q [swmm_pkg::WINDOW_MAX];
	swmm_pkg::sample_t    cmax_q [swmm_pkg::WINDOW_MAX];
	swmm_pkg::sample_t    pmin;
	swmm_pkg::sample_t    pmax;
	swmm_pkg::sample_t    rmin;
	swmm_pkg::sample_t    rmax;
	swmm_pkg::sample_t    rmin_q;
	swmm_pkg::sample_t    rmax_q;
	logic                 rvalid_q;
	logic                 accept;
	logic                 emit;

	assign samples.ready = !rvalid_q || results.ready;
	assign accept        = samples.valid && samples.ready;

	assign ctrl.shift   = accept;
	assign ctrl.restart = samples.stream_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= swmm_pkg::WSIZE_RESET;
		end else if (cfg_we) begin
			wsize_q <= cfg_wdata;
		end
	end

	always_comb begin
		priority if (wsize_q == '0) begin
			weff = swmm_pkg::WSIZE_W'(1);
		end else if (wsize_q > swmm_pkg::WSIZE_W'(swmm_pkg::WINDOW_MAX)) begin
			weff = swmm_pkg::WSIZE_W'(swmm_pkg::WINDOW_MAX);
		end else begin
			weff = wsize_q;
		end
	end

	always_comb begin
		seen_base = samples.stream_start ? '0 : seen_q;
		seen_next = (seen_base < weff) ? seen_base + swmm_pkg::WSIZE_W'(1) : seen_base;
		if (seen_next > weff) begin
			seen_next = weff;
		end
		emit = (seen_next >= weff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (accept) begin
			seen_q <= seen_next;
		end
	end

	genvar k;
	generate
		for (k = 0; k < swmm_pkg::WINDOW_MAX; k++) begin : g_cell
			if (k == 0) begin : g_head
				swmm_cell u_cell (
					.clk      (clk),
					.ctrl     (ctrl),
					.sample   (samples.sample),
					.prev_min (samples.sample),
					.prev_max (samples.sample),
					.min_q    (cmin_q[k]),
					.max_q    (cmax_q[k])
				);
			end else begin : g_body
				swmm_cell u_cell (
					.clk      (clk),
					.ctrl     (ctrl),
					.sample   (samples.sample),
					.prev_min (cmin_q[k-1]),
					.prev_max (cmax_q[k-1]),
					.min_q    (cmin_q[k]),
					.max_q    (cmax_q[k])
				);
			end
		end
	endgenerate

	// result equals what cell weff-1 takes on this beat
	assign sel = swmm_pkg::IDX_W'(weff - swmm_pkg::WSIZE_W'(2));

	always_comb begin
		if (samples.stream_start || weff == swmm_pkg::WSIZE_W'(1)) begin
			pmin = samples.sample;
			pmax = samples.sample;
		end else begin
			pmin = cmin_q[sel];
			pmax = cmax_q[sel];
		end
		rmin = (pmin < samples.sample) ? pmin : samples.sample;
		rmax = (pmax > samples.sample) ? pmax : samples.sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (accept) begin
			rvalid_q <= emit;
		end else if (results.ready) begin
			rvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			rmin_q <= rmin;
			rmax_q <= rmax;
		end
	end

	assign results.valid      = rvalid_q;
	assign results.window_min = rmin_q;
	assign results.window_max = rmax_q;

endmodule

@@ bench/sliding_window_min_max_test.sv @@
class window_board;
	typedef struct {
		swmm_pkg::sample_t val;
		logic [15:0]       pos;
	} slot_t;

	typedef struct {
		swmm_pkg::sample_t lo;
		swmm_pkg::sample_t hi;
	} extremes_t;

	slot_t            min_deque[$];
	slot_t            max_deque[$];
	extremes_t        due_extremes[$];
	logic [15:0]      position;
	int unsigned      filled;
	swmm_pkg::wsize_t window;
	int unsigned      errors;

	function new();
		position = '0;
		filled = 0;
		window = swmm_pkg::WSIZE_RESET;
		errors = 0;
	endfunction

	function void set_window(swmm_pkg::wsize_t w);
		window = w;
	endfunction

	function int pending();
		return due_extremes.size();
	endfunction

	// accepted sample beat: slide both deques and queue the window extremes
	function void note_sample(swmm_pkg::sample_t s, logic start);
		int unsigned span;
		slot_t       fresh;
		extremes_t   ext;
		span = window;
		if (span < 1)
			span = 1;
		if (span > swmm_pkg::WINDOW_MAX)
			span = swmm_pkg::WINDOW_MAX;
		if (start) begin
			min_deque.delete();
			max_deque.delete();
			position = '0;
			filled = 0;
		end
		// ages are modulo 2^16; a shrunk window may expire several heads
		while (min_deque.size() > 0 && 16'(position - min_deque[0].pos) >= span)
			void'(min_deque.pop_front());
		while (max_deque.size() > 0 && 16'(position - max_deque[0].pos) >= span)
			void'(max_deque.pop_front());
		// newer equal samples replace older ones
		while (min_deque.size() > 0 && min_deque[$].val >= s)
			void'(min_deque.pop_back());
		while (max_deque.size() > 0 && max_deque[$].val <= s)
			void'(max_deque.pop_back());
		fresh.val = s;
		fresh.pos = position;
		min_deque.push_back(fresh);
		max_deque.push_back(fresh);
		position = position + 16'd1;
		if (filled < span)
			filled++;
		if (filled > span)
			filled = span;
		if (filled >= span) begin
			ext.lo = min_deque[0].val;
			ext.hi = max_deque[0].val;
			due_extremes.push_back(ext);
		end
	endfunction

	function void check_extremes(swmm_pkg::sample_t mn, swmm_pkg::sample_t mx);
		extremes_t ext;
		if (due_extremes.size() == 0) begin
			$error("window_min/window_max: nothing expected, got %0d/%0d", mn, mx);
			errors++;
			return;
		end
		ext = due_extremes.pop_front();
		if (mn !== ext.lo) begin
			$error("window_min: expected %0d, got %0d", ext.lo, mn);
			errors++;
		end
		if (mx !== ext.hi) begin
			$error("window_max: expected %0d, got %0d", ext.hi, mx);
			errors++;
		end
	endfunction
endclass

module sliding_window_min_max_test;
	typedef swmm_pkg::sample_t sample_t;
	typedef swmm_pkg::wsize_t  wsize_t;

	localparam int QUIET_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 8;
	localparam int PHASES        = 24;
	localparam int PHASE_ITEMS   = 76;
	localparam int FULL_ITEMS    = 50;

	localparam sample_t SMP_LO = {1'b1, {(swmm_pkg::SAMPLE_WIDTH - 1){1'b0}}};
	localparam sample_t SMP_HI = ~SMP_LO;
	localparam wsize_t  WSIZE_TOP = {swmm_pkg::WSIZE_W{1'b1}};

	typedef enum {PAT_WIDE, PAT_NARROW, PAT_EDGES, PAT_RISE, PAT_FALL} pattern_t;
	typedef enum {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idling_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   cfg_we;
	wsize_t cfg_wdata;

	int      tx_idle_pct = 0;
	int      rx_stall_pct = 0;
	int      holds_asked = 0;
	int      quiet_cycles = 0;
	sample_t ramp_val;

	window_board board = new();

	swmm_sample_if sample_ch ();
	swmm_result_if result_ch ();

	sliding_window_min_max dut (
		.clk,
		.arst_n,
		.samples   (sample_ch),
		.results   (result_ch),
		.cfg_we,
		.cfg_wdata
	);

	always #6 clk = ~clk;

	// result sink: random stalls plus the occasional long hold-off
	initial begin
		int hold_left;
		int holds_done;
		hold_left = 0;
		holds_done = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			board.check_extremes(result_ch.window_min, result_ch.window_max);
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idling(idling_t m);
		case (m)
			IDLE_NONE: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			IDLE_TX: begin
				tx_idle_pct = 68;
				rx_stall_pct = 0;
			end
			IDLE_RX: begin
				tx_idle_pct = 0;
				rx_stall_pct = 68;
			end
			default: begin
				tx_idle_pct = 11;
				rx_stall_pct = 11;
			end
		endcase
	endtask

	task automatic push_sample(sample_t s, logic start);
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample <= s;
		sample_ch.stream_start <= start;
		do
			@(posedge clk);
		while (sample_ch.ready !== 1'b1);
		board.note_sample(s, start);
	endtask

	// stop offering beats and let every pending window result come out
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(wsize_t w);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_window(w);
	endtask

	function automatic sample_t next_sample(pattern_t p);
		sample_t s;
		case (p)
			PAT_NARROW: s = sample_t'(int'($urandom_range(6)) - 3);
			PAT_EDGES: begin
				case ($urandom_range(4))
					0: s = SMP_LO;
					1: s = SMP_HI;
					2: s = '0;
					3: s = '1;
					default: s = sample_t'(1);
				endcase
			end
			PAT_RISE: begin
				ramp_val = ramp_val + sample_t'($urandom_range(3));
				s = ramp_val;
			end
			PAT_FALL: begin
				ramp_val = ramp_val - sample_t'($urandom_range(3));
				s = ramp_val;
			end
			default: s = sample_t'($urandom);
		endcase
		return s;
	endfunction

	// runs of one value pattern; rising and falling runs build long deques
	task automatic stream_items(int count, int start_pct);
		pattern_t pat;
		int       run_left;
		int       k;
		run_left = 0;
		pat = PAT_WIDE;
		for (k = 0; k < count; k++) begin
			if (run_left == 0) begin
				pat = pattern_t'($urandom_range(4));
				run_left = 1 + $urandom_range(24);
				ramp_val = sample_t'($urandom);
			end
			run_left--;
			push_sample(next_sample(pat), $urandom_range(99) < start_pct);
		end
	endtask

	initial begin
		int     ph;
		int     start_pct;
		wsize_t w;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample = '0;
		sample_ch.stream_start = 1'b0;
		ramp_val = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window of 3, extremes and equal samples
		set_idling(IDLE_NONE);
		push_sample(SMP_LO, 1'b1);
		push_sample(SMP_HI, 1'b0);
		push_sample('0, 1'b0);
		push_sample('1, 1'b0);
		push_sample(sample_t'(1), 1'b0);
		push_sample(sample_t'(5), 1'b0);
		push_sample(sample_t'(5), 1'b0);
		push_sample(sample_t'(5), 1'b0);
		push_sample(SMP_HI, 1'b0);
		drain();
		write_window(wsize_t'(1));
		push_sample(SMP_HI, 1'b1);
		push_sample(SMP_LO, 1'b0);
		drain();
		// zero behaves as one
		write_window('0);
		push_sample(sample_t'(7), 1'b0);
		drain();
		write_window(wsize_t'(5));
		push_sample(sample_t'(10), 1'b1);
		push_sample(sample_t'(9), 1'b0);
		push_sample(sample_t'(8), 1'b0);
		push_sample(sample_t'(7), 1'b0);
		push_sample(sample_t'(6), 1'b0);
		push_sample(sample_t'(20), 1'b0);
		drain();
		// shrink mid-stream: the oldest min head expires
		write_window(wsize_t'(2));
		push_sample(sample_t'(3), 1'b0);
		push_sample(sample_t'(4), 1'b0);
		drain();
		// grow mid-stream: quiet until the larger window is full
		write_window(wsize_t'(4));
		push_sample(sample_t'(1), 1'b0);
		push_sample(sample_t'(2), 1'b0);
		push_sample(sample_t'(3), 1'b0);
		drain();

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph == 3)
				w = wsize_t'(swmm_pkg::WINDOW_MAX);
			else if (ph == 7)
				w = WSIZE_TOP;
			else begin
				case ($urandom_range(9))
					0: w = '0;
					1: w = wsize_t'(1);
					2: w = wsize_t'(swmm_pkg::WINDOW_MAX);
					3: w = wsize_t'($urandom_range(swmm_pkg::WINDOW_MAX + 1, 127));
					4: w = wsize_t'($urandom_range(17, swmm_pkg::WINDOW_MAX - 1));
					default: w = wsize_t'($urandom_range(2, 16));
				endcase
			end
			start_pct = (w > 16) ? 0 : 3;
			set_idling(idling_t'(ph % 4));
			write_window(w);
			if ($urandom_range(1) == 1)
				push_sample(sample_t'($urandom), 1'b1);
			stream_items(PHASE_ITEMS, start_pct);
			drain();
		end

		// long receiver hold-off while the sender keeps offering
		set_idling(IDLE_NONE);
		write_window(wsize_t'(6));
		holds_asked++;
		stream_items(40, 2);
		drain();

		// widest window, back to back, ending before the first full window
		write_window(wsize_t'(swmm_pkg::WINDOW_MAX));
		push_sample(sample_t'($urandom), 1'b1);
		stream_items(FULL_ITEMS, 0);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
